// ----- hw/rtl/cnm_pkg.sv -----
// ----------------------------------------------------------------------------
// cnm_pkg: shared types and constants of the class nearest match block
// Beat types for both channels, the local table entry and the control
// structures passed between the sequencer and the distance unit.
// ----------------------------------------------------------------------------
package cnm_pkg;

    // Fixed field widths of the beats.
    localparam int FUNC_W        = 2;
    localparam int CLASS_W       = 8;
    localparam int COORD_W       = 16;
    localparam int GIDX_W        = 10;
    localparam int LOCAL_INDEX_W = 6;

    // Queries with a global index at or above this bound match nothing.
    localparam int GLOBAL_DEPTH  = 1024;

    // Squared distance widths: one axis, and the sum of three axes.
    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 2;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd3;

    // Axis codes for the shared distance unit.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Last value of the drain counter that waits for the distance pipeline to empty.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [CLASS_W-1:0]        class_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [GIDX_W-1:0]         global_index;
    } t_in_beat;

    typedef struct packed {
        logic                     found;
        logic [LOCAL_INDEX_W-1:0] local_index;
        logic [GIDX_W-1:0]        matched_global;
        logic                     last;
    } t_out_beat;

    typedef struct packed {
        logic [CLASS_W-1:0]        class_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_entry;

    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
    } t_step;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
    } t_dist_res;

endpackage

// ----- hw/rtl/cnm_table.sv -----
// ----------------------------------------------------------------------------
// cnm_table: local object table
// One write port and one read port with registered read data, holding the
// class and position of every appended local object.
// ----------------------------------------------------------------------------
module cnm_table import cnm_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/cnm_dist_unit.sv -----
// ----------------------------------------------------------------------------
// cnm_dist_unit: shared squared distance unit
// Squares one axis difference per step and accumulates three steps into the
// squared Euclidean distance of one table entry, flagged when classes agree.
// ----------------------------------------------------------------------------
module cnm_dist_unit import cnm_pkg::*; #(
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic [IDX_W-1:0] i_idx,
    input  t_entry           i_entry,
    input  t_entry           i_query,
    output t_dist_res        o_res,
    output logic [IDX_W-1:0] o_idx
);

    logic signed [COORD_W-1:0] sel_a;
    logic signed [COORD_W-1:0] sel_b;
    logic signed [COORD_W:0]   diff;
    logic signed [COORD_W:0]   diff_abs;
    logic [COORD_W-1:0]        mag;
    logic [SQ_W-1:0]           n_sq;
    logic [DIST_W-1:0]         n_acc;

    logic                      r_s1_valid;
    logic [1:0]                r_s1_axis;
    logic                      r_s1_match;
    logic [IDX_W-1:0]          r_s1_idx;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_acc;
    logic                      r_res_valid;
    logic [DIST_W-1:0]         r_res_dist;
    logic [IDX_W-1:0]          r_res_idx;

    // Step one: absolute difference on the selected axis, then its square.
    always_comb begin
        unique case (i_step.axis)
            AXIS_X: begin
                sel_a = i_entry.pos_x;
                sel_b = i_query.pos_x;
            end
            AXIS_Y: begin
                sel_a = i_entry.pos_y;
                sel_b = i_query.pos_y;
            end
            default: begin
                sel_a = i_entry.pos_z;
                sel_b = i_query.pos_z;
            end
        endcase
        diff     = {sel_a[COORD_W-1], sel_a} - {sel_b[COORD_W-1], sel_b};
        diff_abs = diff[COORD_W] ? -diff : diff;
        mag      = diff_abs[COORD_W-1:0];
        n_sq     = SQ_W'(mag) * SQ_W'(mag);
    end

    // Step two: accumulate; the X step restarts the sum.
    assign n_acc = (r_s1_axis == AXIS_X) ? DIST_W'(r_sq) : r_acc + DIST_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_step.valid;
            r_res_valid <= r_s1_valid && (r_s1_axis == AXIS_Z) && r_s1_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_axis  <= i_step.axis;
        r_s1_match <= (i_entry.class_id == i_query.class_id);
        r_s1_idx   <= i_idx;
        r_sq       <= n_sq;
        if (r_s1_valid) begin
            r_acc <= n_acc;
        end
        r_res_dist <= n_acc;
        r_res_idx  <= r_s1_idx;
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.sq_dist = r_res_dist;
    assign o_idx         = r_res_idx;

endmodule

// ----- hw/rtl/class_nearest_match.sv -----
// ----------------------------------------------------------------------------
// class_nearest_match: nearest neighbour association of global objects
// Local object table with class-restricted nearest match and association dump.
// ----------------------------------------------------------------------------
// The block holds up to LOCAL_DEPTH local objects, each a class number and an
// x,y,z position in millimetres. A clear beat empties the table and forgets
// every association, and an append beat adds one object unless the table is
// full; both give no result and leave the sequencer idle. A query beat scans
// the stored objects of the same class for the least squared distance, the
// first strict minimum winning, returns one result beat and records the global
// index against the local object found. One shared squared-difference
// multiplier handles one axis of one entry per cycle, so a query keeps the
// input stalled while it scans every stored entry, drains the distance
// pipeline and loads the output register; the scan is skipped when the table
// is empty or the global index is out of range.
// A dump beat gives one result beat per stored object in index order, each
// after a registered read of the association memory, with the last beat
// flagged. An output register lets the block take the next input beat while
// the previous result still waits downstream.
// ----------------------------------------------------------------------------
module class_nearest_match import cnm_pkg::*; #(
    parameter int LOCAL_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int IDX_W = $clog2(LOCAL_DEPTH);
    localparam int CNT_W = $clog2(LOCAL_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_QOUT  = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DOUT  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [1:0]             r_axis, n_axis;
    logic [1:0]             r_drain, n_drain;
    logic                   r_have, n_have;
    logic [DIST_W-1:0]      r_best, n_best;
    logic [IDX_W-1:0]       r_best_idx, n_best_idx;
    logic [LOCAL_DEPTH-1:0] r_assoc_valid, n_assoc_valid;
    logic                   r_out_valid, n_out_valid;
    t_out_beat              r_out, n_out;
    t_in_beat               r_query, n_query;
    t_step                  r_step;
    logic [IDX_W-1:0]       r_step_idx;

    // Association memory: global index recorded against each local object.
    logic [GIDX_W-1:0]      r_assoc_mem [LOCAL_DEPTH];
    logic [GIDX_W-1:0]      r_assoc_rd;

    logic                   in_accept;
    logic                   out_free;
    logic                   last_idx;
    logic                   tbl_we;
    logic                   assoc_we;
    t_entry                 tbl_wr_data;
    t_entry                 tbl_rd_data;
    t_entry                 query_entry;
    t_dist_res              dist_res;
    logic [IDX_W-1:0]       dist_idx;

    // Input beats are taken only while the sequencer rests; clear and append
    // finish in the accepting cycle itself.
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // The output register may be reloaded when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // True when the current index points at the last stored object.
    assign last_idx = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    always_comb begin
        tbl_wr_data.class_id = i_in.class_id;
        tbl_wr_data.pos_x    = i_in.pos_x;
        tbl_wr_data.pos_y    = i_in.pos_y;
        tbl_wr_data.pos_z    = i_in.pos_z;
        query_entry.class_id = r_query.class_id;
        query_entry.pos_x    = r_query.pos_x;
        query_entry.pos_y    = r_query.pos_y;
        query_entry.pos_z    = r_query.pos_z;
    end

    cnm_table #(
        .DEPTH (LOCAL_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (tbl_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (tbl_rd_data)
    );

    cnm_dist_unit #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_step),
        .i_idx   (r_step_idx),
        .i_entry (tbl_rd_data),
        .i_query (query_entry),
        .o_res   (dist_res),
        .o_idx   (dist_idx)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_axis        = r_axis;
        n_drain       = r_drain;
        n_have        = r_have;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_assoc_valid = r_assoc_valid;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_query       = r_query;
        tbl_we        = 1'b0;
        assoc_we      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Running minimum over same-class entries; a tie keeps the earlier one.
        if (dist_res.valid && (!r_have || (dist_res.sq_dist < r_best))) begin
            n_have     = 1'b1;
            n_best     = dist_res.sq_dist;
            n_best_idx = dist_idx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_query = i_in;
                    unique case (i_in.func)
                        FUNC_CLEAR: begin
                            n_count       = '0;
                            n_assoc_valid = '0;
                        end
                        FUNC_APPEND: begin
                            if (r_count < CNT_W'(LOCAL_DEPTH)) begin
                                tbl_we = 1'b1;
                                n_assoc_valid[r_count[IDX_W-1:0]] = 1'b0;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_QUERY: begin
                            n_have  = 1'b0;
                            n_idx   = '0;
                            n_axis  = AXIS_X;
                            n_drain = '0;
                            if ((r_count != '0) &&
                                (32'(i_in.global_index) < 32'(GLOBAL_DEPTH))) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_QOUT;
                            end
                        end
                        FUNC_DUMP: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_DRD;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Three axis steps per entry, then on to the next entry.
                if (r_axis == AXIS_Z) begin
                    n_axis = AXIS_X;
                    if (last_idx) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_LAST) begin
                    n_state = S_QOUT;
                end else begin
                    n_drain = r_drain + 2'd1;
                end
            end
            S_QOUT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.found          = r_have;
                    n_out.local_index    = r_have ? LOCAL_INDEX_W'(r_best_idx) : '0;
                    n_out.matched_global = r_query.global_index;
                    n_out.last           = 1'b1;
                    if (r_have) begin
                        n_assoc_valid[r_best_idx] = 1'b1;
                        assoc_we = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.found          = r_assoc_valid[r_idx];
                    n_out.local_index    = LOCAL_INDEX_W'(r_idx);
                    n_out.matched_global = r_assoc_valid[r_idx] ? r_assoc_rd : '0;
                    n_out.last           = last_idx;
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_have        <= 1'b0;
            r_assoc_valid <= '0;
            r_out_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_have        <= n_have;
            r_assoc_valid <= n_assoc_valid;
            r_out_valid   <= n_out_valid;
            r_step.valid  <= (r_state == S_SCAN);
            r_step.axis   <= r_axis;
        end
    end

    // Payload and counters that are always set before they are used.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_axis     <= n_axis;
        r_drain    <= n_drain;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_out      <= n_out;
        r_query    <= n_query;
        r_step_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (assoc_we) begin
            r_assoc_mem[r_best_idx] <= r_query.global_index;
        end
        r_assoc_rd <= r_assoc_mem[r_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The table never holds more objects than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOCAL_DEPTH))
        else $error("local object count beyond table depth");

    // The scan only visits stored objects.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan index beyond stored objects");

    // Distance results only arrive while a query scan is in flight.
    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_res.valid |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("distance result outside a query scan");

    // A query that found a match leaves that object associated.
    a_query_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_QOUT) && out_free && r_have)
        |=> r_assoc_valid[$past(r_best_idx)])
        else $error("matched query did not record its association");

endmodule

// ----- bench/tb_class_nearest_match.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_class_nearest_match: self-checking bench for the nearest match block
// Drives clear, append, query and dump beats with bursty timing, mirrors the
// local table and its associations to predict every result beat, and checks
// each result field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_class_nearest_match;
    import cnm_pkg::*;

    localparam int LOCAL_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 350;
    // Sized from the longest query, a scan over a full table, with room to spare for the tail.
    localparam int END_DRAIN    = 3 * LOCAL_DEPTH + 40;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 400;

    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Receiver behaviours, changed every so often by the stall process.
    typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_COMB, RX_HEAVY} t_rx_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    logic      o_in_stall;
    t_in_beat  in_beat     = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out;

    class_nearest_match #(
        .LOCAL_DEPTH (LOCAL_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Mirror of the block's state. It is updated only when a beat is actually
    // accepted, so the expected results follow the order the block sees.
    // ------------------------------------------------------------------------
    t_entry            obj_tab     [LOCAL_DEPTH];
    logic              link_valid  [LOCAL_DEPTH];
    logic [GIDX_W-1:0] link_global [LOCAL_DEPTH];
    int                obj_count = 0;

    t_in_beat  beats_to_send[$];
    t_out_beat assoc_results_due[$];

    int beats_pushed = 0;
    int beats_taken  = 0;
    int beats_seen   = 0;
    int err_count    = 0;

    // Stimulus-side bookkeeping: how full the table will be once the queued
    // beats have gone in, so that ignored appends are not counted as work.
    int gen_fill   = 0;
    int stim_count = 0;

    function automatic longint axis_sq(logic signed [COORD_W-1:0] a,
                                       logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // Works out what one accepted beat does to the table and which result
    // beats it must produce, queuing those in order.
    function automatic void predict_association(t_in_beat b);
        t_out_beat r;
        logic      hit;
        longint    best;
        longint    sq_sum;
        int        best_j;
        hit    = 1'b0;
        best   = 0;
        best_j = 0;
        case (b.func)
            FUNC_CLEAR: begin
                obj_count = 0;
                for (int j = 0; j < LOCAL_DEPTH; j++) link_valid[j] = 1'b0;
            end
            FUNC_APPEND: begin
                // A full table simply ignores the append.
                if (obj_count < LOCAL_DEPTH) begin
                    obj_tab[obj_count] = '{b.class_id, b.pos_x, b.pos_y, b.pos_z};
                    link_valid[obj_count] = 1'b0;
                    obj_count++;
                end
            end
            FUNC_QUERY: begin
                if (b.global_index < GLOBAL_DEPTH) begin
                    for (int j = 0; j < obj_count; j++) begin
                        if (obj_tab[j].class_id == b.class_id) begin
                            sq_sum = axis_sq(obj_tab[j].pos_x, b.pos_x)
                                   + axis_sq(obj_tab[j].pos_y, b.pos_y)
                                   + axis_sq(obj_tab[j].pos_z, b.pos_z);
                            // Only a strictly smaller distance displaces the
                            // earlier candidate, so ties go to the lower index.
                            if (!hit || sq_sum < best) begin
                                hit    = 1'b1;
                                best   = sq_sum;
                                best_j = j;
                            end
                        end
                    end
                end
                if (hit) begin
                    link_valid[best_j]  = 1'b1;
                    link_global[best_j] = b.global_index;
                end
                r.found          = hit;
                r.local_index    = LOCAL_INDEX_W'(best_j);
                r.matched_global = b.global_index;
                r.last           = 1'b1;
                assoc_results_due = {assoc_results_due, r};
            end
            FUNC_DUMP: begin
                // One beat per stored object; an empty table gives nothing.
                for (int j = 0; j < obj_count; j++) begin
                    r.found          = link_valid[j];
                    r.local_index    = LOCAL_INDEX_W'(j);
                    r.matched_global = link_valid[j] ? link_global[j] : '0;
                    r.last           = (j == obj_count - 1);
                    assoc_results_due = {assoc_results_due, r};
                end
            end
        endcase
    endfunction

    task automatic push_item(logic [FUNC_W-1:0] f, logic [CLASS_W-1:0] cls,
                             logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z,
                             logic [GIDX_W-1:0] g);
        t_in_beat b;
        b = '{f, cls, x, y, z, g};
        beats_to_send = {beats_to_send, b};
        beats_pushed++;
        if (f == FUNC_CLEAR) begin
            gen_fill = 0;
            stim_count++;
        end else if (f == FUNC_APPEND) begin
            if (gen_fill < LOCAL_DEPTH) begin
                gen_fill++;
                stim_count++;
            end
        end else begin
            stim_count++;
        end
    endtask

    // Half the time clustered around a centre so that classes compete on distance,
    // otherwise the extremes or wholly random values.
    function automatic logic signed [COORD_W-1:0] near_coord(
            logic signed [COORD_W-1:0] centre);
        case ($urandom_range(0, 7))
            0:       return C_MIN;
            1:       return C_MAX;
            2, 3:    return COORD_W'($urandom);
            default: return centre + COORD_W'($urandom_range(0, 600)) - COORD_W'(300);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver. The sender works in bursts; between bursts it idles for a random
    // gap, sometimes none at all. A stalled beat is held unchanged.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_association(in_beat);
                beats_taken++;
            end
            if (!(in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    in_beat  <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall. The mode is redrawn at random whenever its countdown runs out.
    // Once enough results have come back, the receiver holds off for a long
    // stretch so that the output register fills and the block stalls its
    // input while the sender keeps offering beats.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode    = RX_FLOW;
    int       mode_left  = 0;
    int       hold_left  = 0;
    logic     hold_done  = 1'b0;
    int       comb_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            comb_phase = (comb_phase + 1) % 5;
            case (rx_mode)
                RX_FLOW:   i_out_stall <= 1'b0;
                RX_RANDOM: i_out_stall <= ($urandom_range(0, 1) == 1);
                RX_COMB:   i_out_stall <= (comb_phase < 2);
                RX_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every accepted result beat is compared with the oldest one
    // still due; a beat with nothing due is itself a failure.
    // ------------------------------------------------------------------------
    t_out_beat want_beat;

    task automatic compare_field(string name, logic [GIDX_W-1:0] want,
                                 logic [GIDX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_seen++;
            if (assoc_results_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, o_out);
                err_count++;
            end else begin
                want_beat = assoc_results_due.pop_front();
                compare_field("found", GIDX_W'(want_beat.found), GIDX_W'(o_out.found));
                compare_field("local_index", GIDX_W'(want_beat.local_index),
                              GIDX_W'(o_out.local_index));
                compare_field("matched_global", want_beat.matched_global,
                              o_out.matched_global);
                compare_field("last", GIDX_W'(want_beat.last), GIDX_W'(o_out.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                        n_obj;
        int                        n_ask;
        logic [CLASS_W-1:0]        base;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;

        // Directed part. A dump and a query on the empty table come first.
        push_item(FUNC_DUMP,   8'd0,   '0, '0, '0, 10'd0);
        push_item(FUNC_QUERY,  8'd0,   '0, '0, '0, 10'd1023);
        // Extreme coordinates, with a duplicate entry to force a tie.
        push_item(FUNC_APPEND, 8'd255, C_MAX, C_MAX, C_MAX, 10'd0);
        push_item(FUNC_APPEND, 8'd255, C_MIN, C_MIN, C_MIN, 10'd0);
        push_item(FUNC_APPEND, 8'd0,   '0, '0, '0, 10'd0);
        push_item(FUNC_APPEND, 8'd255, C_MAX, C_MAX, C_MAX, 10'd0);
        // Tie between entries 0 and 3: the lower index must win.
        push_item(FUNC_QUERY,  8'd255, C_MAX, C_MAX, C_MAX, 10'd0);
        // Largest possible distances to the other same-class entries.
        push_item(FUNC_QUERY,  8'd255, C_MIN, C_MIN, C_MIN, 10'd1023);
        // A later query overwrites the association of entry 0.
        push_item(FUNC_QUERY,  8'd255, C_MAX, C_MAX, C_MAX, 10'd5);
        // No local object of this class.
        push_item(FUNC_QUERY,  8'd7,   '0, '0, '0, 10'd100);
        push_item(FUNC_QUERY,  8'd0,   C_MIN, C_MAX, C_MIN, 10'h2AA);
        push_item(FUNC_DUMP,   8'd0,   '0, '0, '0, 10'd0);
        push_item(FUNC_APPEND, 8'h55,  16'sh5555, 16'sh5555, 16'sh5555, 10'h155);
        push_item(FUNC_APPEND, 8'hAA,  16'shAAAA, 16'shAAAA, 16'shAAAA, 10'h2AA);
        push_item(FUNC_QUERY,  8'hAA,  16'sh5555, 16'shAAAA, 16'sh5555, 10'h155);
        push_item(FUNC_DUMP,   8'hFF,  C_MAX, C_MIN, C_MAX, 10'h3FF);
        // Clear forgets the table, so a dump is empty and a query misses.
        push_item(FUNC_CLEAR,  8'hFF,  C_MAX, C_MAX, C_MAX, 10'h3FF);
        push_item(FUNC_DUMP,   8'd0,   '0, '0, '0, 10'd0);
        push_item(FUNC_QUERY,  8'd255, C_MAX, C_MAX, C_MAX, 10'd9);
        push_item(FUNC_APPEND, 8'd1,   16'sd100, -16'sd100, 16'sd50, 10'd0);
        push_item(FUNC_QUERY,  8'd1,   -16'sd3, 16'sd7, 16'sd0, 10'd341);
        push_item(FUNC_DUMP,   8'd0,   '0, '0, '0, 10'd0);

        // Random part: mostly well-formed sessions (clear, a batch of appends,
        // queries with the odd dump, a closing dump), some of them filling
        // the table past its depth, with bursts of unstructured noise between.
        stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    push_item(FUNC_W'($urandom), CLASS_W'($urandom), COORD_W'($urandom),
                              COORD_W'($urandom), COORD_W'($urandom), GIDX_W'($urandom));
                end
            end else begin
                base = CLASS_W'($urandom);
                cx   = COORD_W'($urandom);
                cy   = COORD_W'($urandom);
                cz   = COORD_W'($urandom);
                push_item(FUNC_CLEAR, CLASS_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom), GIDX_W'($urandom));
                n_obj = ($urandom_range(0, 4) == 0) ? $urandom_range(LOCAL_DEPTH - 2,
                                                                      LOCAL_DEPTH + 4)
                                                    : $urandom_range(1, 8);
                repeat (n_obj) begin
                    push_item(FUNC_APPEND, base + CLASS_W'($urandom_range(0, 2)),
                              near_coord(cx), near_coord(cy), near_coord(cz),
                              GIDX_W'($urandom));
                end
                n_ask = $urandom_range(1, 10);
                repeat (n_ask) begin
                    push_item(FUNC_QUERY, base + CLASS_W'($urandom_range(0, 3)),
                              near_coord(cx), near_coord(cy), near_coord(cz),
                              GIDX_W'($urandom));
                    if ($urandom_range(0, 5) == 0) begin
                        push_item(FUNC_DUMP, CLASS_W'($urandom), COORD_W'($urandom),
                                  COORD_W'($urandom), COORD_W'($urandom),
                                  GIDX_W'($urandom));
                    end
                end
                push_item(FUNC_DUMP, CLASS_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom), GIDX_W'($urandom));
            end
        end

        // Reset is released once the stimulus is queued and never asserted again.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken, then for every result to return,
        // then a little longer so that any stray extra beat is caught.
        while (beats_taken != beats_pushed) @(posedge i_clk);
        while (assoc_results_due.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, set several times above the slowest legal run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- class_nearest_match.f -----
hw/rtl/cnm_pkg.sv
hw/rtl/cnm_table.sv
hw/rtl/cnm_dist_unit.sv
hw/rtl/class_nearest_match.sv
bench/tb_class_nearest_match.sv
